>>> hdl/lazy_segment_tree_add_sum_top_macros.svh
// Assertion macros used by the checker file of the lazy segment tree block.
`ifndef LAZY_SEGMENT_TREE_ADD_SUM_TOP_MACROS_SVH
`define LAZY_SEGMENT_TREE_ADD_SUM_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LST_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/lst_pkg.sv
// Types, constants and codes shared by the lazy segment tree block.
`default_nettype none

package lst_pkg;

    localparam int MAX_LEAVES  = 1024;
    localparam int TREE_NODES  = 2 * MAX_LEAVES;
    localparam int NODE_W      = $clog2(TREE_NODES);
    localparam int CNT_W       = $clog2(MAX_LEAVES + 1);
    localparam int STACK_DEPTH = NODE_W;
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int SUM_W       = 64;
    localparam int ACT_W       = 18;
    localparam int NODE_DW     = SUM_W + ACT_W;
    localparam int HALF_W      = 32;
    localparam int PROD_W      = HALF_W + ACT_W;

    localparam logic [1:0] OP_SET   = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic STATUS_DONE   = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    localparam logic [1:0] PH_ENTER     = 2'd0;
    localparam logic [1:0] PH_LEFT_DONE = 2'd1;
    localparam logic [1:0] PH_BOTH_DONE = 2'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [9:0]         left_index;
        logic [10:0]        right_bound;
        logic signed [63:0] amount;
        logic [7:0]         leaf_active;
    } in_item_t;

    typedef struct packed {
        logic signed [63:0] range_sum;
        logic [17:0]        range_active;
        logic               status;
    } out_item_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECIDE,
        ST_PD_RD,
        ST_PD_WAIT,
        ST_TAG_RD,
        ST_TAG_WAIT,
        ST_TAG_MLO,
        ST_TAG_MHI,
        ST_TAG_WR,
        ST_PD_CLR,
        ST_DESCEND,
        ST_Q_RD,
        ST_Q_WAIT,
        ST_PU_RDA,
        ST_PU_RDB,
        ST_PU_WR,
        ST_POP,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

>>> hdl/lst_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module lst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hdl/lazy_segment_tree_add_sum_top.sv
// Top level of the lazy segment tree with range add and range sum.
// Usage:
// The input channel (in_valid, in_ready, in_data) takes one operation per transfer:
// point set, range add or range query. The output channel (out_valid, out_ready,
// out_data) returns exactly one result per operation, in order. The configuration
// channel (cfg_valid, cfg_ready, cfg_data) writes leaf_count and clears the tree.
// Operations run one at a time as a walk over the tree held in two node memories, one
// for sums with active counts and one for pending tags, sharing one read and one write
// address per cycle. A skipped node is popped, a covered node is read for a query or
// tagged for an add, and a split node first pushes a nonzero tag down to both children
// and, for an add or a set, re-sums its children on the way back. A rejected or empty
// item goes straight to its result.
// After reset, and after every configuration write, a clearing pass zeroes the
// memories while in_ready stays low; configuration transfers are still taken.
// The result sits in an output register, so a stalled receiver holds only that result;
// the block takes the next item meanwhile and waits only to deliver its own result.
`default_nettype none

module lazy_segment_tree_add_sum_top (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire lst_pkg::in_item_t       in_data,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output lst_pkg::out_item_t           out_data,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [10:0]             cfg_data
);

    lst_pkg::state_t state_reg, state_next;

    logic [lst_pkg::NODE_W-1:0] clr_cnt_reg;
    logic [lst_pkg::CNT_W-1:0]  leaf_count_reg;
    logic [lst_pkg::SP_W-1:0]   sp_reg;
    logic                       out_valid_reg;

    logic [lst_pkg::NODE_W-1:0] stk_p_reg  [lst_pkg::STACK_DEPTH];
    logic [lst_pkg::CNT_W-1:0]  stk_l_reg  [lst_pkg::STACK_DEPTH];
    logic [lst_pkg::CNT_W-1:0]  stk_r_reg  [lst_pkg::STACK_DEPTH];
    logic [1:0]                 stk_ph_reg [lst_pkg::STACK_DEPTH];

    lst_pkg::in_item_t          item_reg;
    lst_pkg::out_item_t         out_data_reg;
    logic                       status_reg;
    logic [lst_pkg::SUM_W-1:0]  acc_sum_reg;
    logic [lst_pkg::ACT_W-1:0]  acc_act_reg;
    logic [lst_pkg::NODE_W-1:0] tag_node_reg;
    logic [lst_pkg::SUM_W-1:0]  tag_val_reg;
    logic                       tag_cover_reg;
    logic                       tag_right_reg;
    logic [lst_pkg::SUM_W-1:0]  csum_reg;
    logic [lst_pkg::ACT_W-1:0]  cact_reg;
    logic [lst_pkg::SUM_W-1:0]  cpend_reg;
    logic [lst_pkg::PROD_W-1:0] prod_lo_reg;
    logic [lst_pkg::HALF_W-1:0] prod_hi_reg;
    logic [lst_pkg::SUM_W-1:0]  tmp_sum_reg;
    logic [lst_pkg::ACT_W-1:0]  tmp_act_reg;

    logic                       in_fire, cfg_fire, out_free;
    logic [lst_pkg::CNT_W-1:0]  in_x, in_y, cfg_val;
    logic                       start_bad, start_work;

    logic [lst_pkg::IDX_W-1:0]  top_idx, push_idx;
    logic [lst_pkg::NODE_W-1:0] top_p, p2, p2b;
    logic [lst_pkg::CNT_W-1:0]  top_l, top_r, mid, x, y;
    logic [lst_pkg::CNT_W:0]    mid_sum;
    logic [1:0]                 top_ph;
    logic                       disjoint, covered, is_leaf, is_set, is_add;

    logic [lst_pkg::NODE_W-1:0]  mem_raddr, mem_waddr;
    logic                        node_we, pend_we;
    logic [lst_pkg::SUM_W-1:0]   sum_wdata, pend_wdata, sum_rdata, pend_rdata;
    logic [lst_pkg::ACT_W-1:0]   act_wdata, act_rdata;
    logic [lst_pkg::NODE_DW-1:0] node_wdata, node_rdata;

    assign in_ready  = (state_reg == lst_pkg::ST_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == lst_pkg::ST_IDLE) || (state_reg == lst_pkg::ST_CLEAR);
    assign in_fire   = in_valid && in_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign in_x = lst_pkg::CNT_W'(in_data.left_index);
    assign in_y = lst_pkg::CNT_W'(in_data.right_bound);

    assign node_wdata = {sum_wdata, act_wdata};
    assign sum_rdata  = node_rdata[lst_pkg::NODE_DW-1:lst_pkg::ACT_W];
    assign act_rdata  = node_rdata[lst_pkg::ACT_W-1:0];

    always_comb
    begin
        unique case (in_data.opcode)
            lst_pkg::OP_SET:
            begin
                start_bad  = in_x >= leaf_count_reg;
                start_work = !start_bad;
            end
            lst_pkg::OP_ADD, lst_pkg::OP_QUERY:
            begin
                start_bad  = (in_x > leaf_count_reg) || (in_y > leaf_count_reg);
                start_work = !start_bad && (in_x < in_y);
            end
            default:
            begin
                start_bad  = 1'b1;
                start_work = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        cfg_val = cfg_data;
        if (cfg_data == '0)
        begin
            cfg_val = lst_pkg::CNT_W'(1);
        end
        else if (cfg_data > lst_pkg::CNT_W'(lst_pkg::MAX_LEAVES))
        begin
            cfg_val = lst_pkg::CNT_W'(lst_pkg::MAX_LEAVES);
        end
    end

    assign top_idx  = lst_pkg::IDX_W'(sp_reg - 1'b1);
    assign push_idx = sp_reg[lst_pkg::IDX_W-1:0];
    assign top_p    = stk_p_reg[top_idx];
    assign top_l    = stk_l_reg[top_idx];
    assign top_r    = stk_r_reg[top_idx];
    assign top_ph   = stk_ph_reg[top_idx];
    assign p2       = {top_p[lst_pkg::NODE_W-2:0], 1'b0};
    assign p2b      = {top_p[lst_pkg::NODE_W-2:0], 1'b1};
    assign mid_sum  = {1'b0, top_l} + {1'b0, top_r};
    assign mid      = mid_sum[lst_pkg::CNT_W:1];
    assign x        = lst_pkg::CNT_W'(item_reg.left_index);
    assign y        = lst_pkg::CNT_W'(item_reg.right_bound);
    assign disjoint = (top_l >= y) || (top_r <= x);
    assign covered  = (top_l >= x) && (top_r <= y);
    assign is_leaf  = (top_r - top_l) == lst_pkg::CNT_W'(1);
    assign is_set   = item_reg.opcode == lst_pkg::OP_SET;
    assign is_add   = item_reg.opcode == lst_pkg::OP_ADD;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lst_pkg::ST_CLEAR:
            begin
                if (!cfg_fire && (clr_cnt_reg == '1))
                begin
                    state_next = lst_pkg::ST_IDLE;
                end
            end
            lst_pkg::ST_IDLE:
            begin
                if (cfg_fire)
                begin
                    state_next = lst_pkg::ST_CLEAR;
                end
                else if (in_fire)
                begin
                    state_next = start_work ? lst_pkg::ST_DECIDE : lst_pkg::ST_DONE;
                end
            end
            lst_pkg::ST_DECIDE:
            begin
                if (is_set)
                begin
                    if (top_ph == lst_pkg::PH_ENTER)
                    begin
                        state_next = is_leaf ? lst_pkg::ST_POP : lst_pkg::ST_PD_RD;
                    end
                    else
                    begin
                        state_next = lst_pkg::ST_PU_RDA;
                    end
                end
                else if (top_ph == lst_pkg::PH_ENTER)
                begin
                    if (disjoint)
                    begin
                        state_next = lst_pkg::ST_POP;
                    end
                    else if (covered)
                    begin
                        state_next = is_add ? lst_pkg::ST_TAG_RD : lst_pkg::ST_Q_RD;
                    end
                    else
                    begin
                        state_next = lst_pkg::ST_PD_RD;
                    end
                end
                else if (top_ph == lst_pkg::PH_LEFT_DONE)
                begin
                    state_next = lst_pkg::ST_DECIDE;
                end
                else
                begin
                    state_next = is_add ? lst_pkg::ST_PU_RDA : lst_pkg::ST_POP;
                end
            end
            lst_pkg::ST_PD_RD:    state_next = lst_pkg::ST_PD_WAIT;
            lst_pkg::ST_PD_WAIT:
            begin
                state_next = (pend_rdata == '0) ? lst_pkg::ST_DESCEND : lst_pkg::ST_TAG_RD;
            end
            lst_pkg::ST_TAG_RD:   state_next = lst_pkg::ST_TAG_WAIT;
            lst_pkg::ST_TAG_WAIT: state_next = lst_pkg::ST_TAG_MLO;
            lst_pkg::ST_TAG_MLO:  state_next = lst_pkg::ST_TAG_MHI;
            lst_pkg::ST_TAG_MHI:  state_next = lst_pkg::ST_TAG_WR;
            lst_pkg::ST_TAG_WR:
            begin
                if (tag_cover_reg)
                begin
                    state_next = lst_pkg::ST_POP;
                end
                else if (!tag_right_reg)
                begin
                    state_next = lst_pkg::ST_TAG_RD;
                end
                else
                begin
                    state_next = lst_pkg::ST_PD_CLR;
                end
            end
            lst_pkg::ST_PD_CLR:   state_next = lst_pkg::ST_DESCEND;
            lst_pkg::ST_DESCEND:  state_next = lst_pkg::ST_DECIDE;
            lst_pkg::ST_Q_RD:     state_next = lst_pkg::ST_Q_WAIT;
            lst_pkg::ST_Q_WAIT:   state_next = lst_pkg::ST_POP;
            lst_pkg::ST_PU_RDA:   state_next = lst_pkg::ST_PU_RDB;
            lst_pkg::ST_PU_RDB:   state_next = lst_pkg::ST_PU_WR;
            lst_pkg::ST_PU_WR:    state_next = lst_pkg::ST_POP;
            lst_pkg::ST_POP:
            begin
                state_next = (sp_reg == lst_pkg::SP_W'(1)) ? lst_pkg::ST_DONE
                                                            : lst_pkg::ST_DECIDE;
            end
            lst_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = lst_pkg::ST_IDLE;
                end
            end
            default:              state_next = lst_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        mem_raddr  = '0;
        mem_waddr  = top_p;
        node_we    = 1'b0;
        pend_we    = 1'b0;
        sum_wdata  = '0;
        act_wdata  = '0;
        pend_wdata = '0;
        unique case (state_reg)
            lst_pkg::ST_CLEAR:
            begin
                mem_waddr = clr_cnt_reg;
                node_we   = 1'b1;
                pend_we   = 1'b1;
            end
            lst_pkg::ST_DECIDE:
            begin
                if (is_set && (top_ph == lst_pkg::PH_ENTER) && is_leaf)
                begin
                    node_we   = 1'b1;
                    sum_wdata = item_reg.amount;
                    act_wdata = lst_pkg::ACT_W'(item_reg.leaf_active);
                end
            end
            lst_pkg::ST_PD_RD, lst_pkg::ST_Q_RD:
            begin
                mem_raddr = top_p;
            end
            lst_pkg::ST_TAG_RD:
            begin
                mem_raddr = tag_node_reg;
            end
            lst_pkg::ST_TAG_WR:
            begin
                mem_waddr  = tag_node_reg;
                node_we    = 1'b1;
                pend_we    = 1'b1;
                sum_wdata  = csum_reg + lst_pkg::SUM_W'(prod_lo_reg)
                           + {prod_hi_reg, lst_pkg::HALF_W'(0)};
                act_wdata  = cact_reg;
                pend_wdata = cpend_reg + tag_val_reg;
            end
            lst_pkg::ST_PD_CLR:
            begin
                pend_we = 1'b1;
            end
            lst_pkg::ST_PU_RDA:
            begin
                mem_raddr = p2;
            end
            lst_pkg::ST_PU_RDB:
            begin
                mem_raddr = p2b;
            end
            lst_pkg::ST_PU_WR:
            begin
                node_we   = 1'b1;
                sum_wdata = tmp_sum_reg + sum_rdata;
                act_wdata = tmp_act_reg + act_rdata;
            end
            default:
            begin
                mem_raddr = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lst_pkg::ST_CLEAR;
            clr_cnt_reg    <= '0;
            leaf_count_reg <= lst_pkg::CNT_W'(lst_pkg::MAX_LEAVES);
            sp_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_fire)
            begin
                leaf_count_reg <= cfg_val;
                clr_cnt_reg    <= '0;
            end
            else if (state_reg == lst_pkg::ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (in_fire)
            begin
                sp_reg <= start_work ? lst_pkg::SP_W'(1) : '0;
            end
            else if ((state_reg == lst_pkg::ST_DESCEND)
                     || ((state_reg == lst_pkg::ST_DECIDE) && !is_set
                         && (top_ph == lst_pkg::PH_LEFT_DONE)))
            begin
                sp_reg <= sp_reg + 1'b1;
            end
            else if (state_reg == lst_pkg::ST_POP)
            begin
                sp_reg <= sp_reg - 1'b1;
            end
            if ((state_reg == lst_pkg::ST_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            lst_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    item_reg                      <= in_data;
                    status_reg                    <= start_bad ? lst_pkg::STATUS_REJECT
                                                               : lst_pkg::STATUS_DONE;
                    acc_sum_reg                   <= '0;
                    acc_act_reg                   <= '0;
                    stk_p_reg[0]                  <= lst_pkg::NODE_W'(1);
                    stk_l_reg[0]                  <= '0;
                    stk_r_reg[0]                  <= leaf_count_reg;
                    stk_ph_reg[0]                 <= lst_pkg::PH_ENTER;
                end
            end
            lst_pkg::ST_DECIDE:
            begin
                if (!is_set && (top_ph == lst_pkg::PH_ENTER) && !disjoint && covered)
                begin
                    tag_node_reg  <= top_p;
                    tag_val_reg   <= item_reg.amount;
                    tag_cover_reg <= 1'b1;
                end
                if (!is_set && (top_ph == lst_pkg::PH_LEFT_DONE))
                begin
                    stk_ph_reg[top_idx] <= lst_pkg::PH_BOTH_DONE;
                    stk_p_reg[push_idx]  <= p2b;
                    stk_l_reg[push_idx]  <= mid;
                    stk_r_reg[push_idx]  <= top_r;
                    stk_ph_reg[push_idx] <= lst_pkg::PH_ENTER;
                end
            end
            lst_pkg::ST_PD_WAIT:
            begin
                tag_node_reg  <= p2;
                tag_val_reg   <= pend_rdata;
                tag_cover_reg <= 1'b0;
                tag_right_reg <= 1'b0;
            end
            lst_pkg::ST_TAG_WAIT:
            begin
                csum_reg  <= sum_rdata;
                cact_reg  <= act_rdata;
                cpend_reg <= pend_rdata;
            end
            lst_pkg::ST_TAG_MLO:
            begin
                prod_lo_reg <= lst_pkg::PROD_W'(tag_val_reg[lst_pkg::HALF_W-1:0])
                             * lst_pkg::PROD_W'(cact_reg);
            end
            lst_pkg::ST_TAG_MHI:
            begin
                prod_hi_reg <= lst_pkg::HALF_W'(tag_val_reg[lst_pkg::SUM_W-1:lst_pkg::HALF_W]
                                                * lst_pkg::HALF_W'(cact_reg));
            end
            lst_pkg::ST_TAG_WR:
            begin
                if (!tag_cover_reg && !tag_right_reg)
                begin
                    tag_node_reg  <= tag_node_reg | lst_pkg::NODE_W'(1);
                    tag_right_reg <= 1'b1;
                end
            end
            lst_pkg::ST_DESCEND:
            begin
                stk_ph_reg[push_idx] <= lst_pkg::PH_ENTER;
                if (is_set)
                begin
                    stk_ph_reg[top_idx] <= lst_pkg::PH_BOTH_DONE;
                    if (x < mid)
                    begin
                        stk_p_reg[push_idx] <= p2;
                        stk_l_reg[push_idx] <= top_l;
                        stk_r_reg[push_idx] <= mid;
                    end
                    else
                    begin
                        stk_p_reg[push_idx] <= p2b;
                        stk_l_reg[push_idx] <= mid;
                        stk_r_reg[push_idx] <= top_r;
                    end
                end
                else
                begin
                    stk_ph_reg[top_idx] <= lst_pkg::PH_LEFT_DONE;
                    stk_p_reg[push_idx] <= p2;
                    stk_l_reg[push_idx] <= top_l;
                    stk_r_reg[push_idx] <= mid;
                end
            end
            lst_pkg::ST_Q_WAIT:
            begin
                acc_sum_reg <= acc_sum_reg + sum_rdata;
                acc_act_reg <= acc_act_reg + act_rdata;
            end
            lst_pkg::ST_PU_RDB:
            begin
                tmp_sum_reg <= sum_rdata;
                tmp_act_reg <= act_rdata;
            end
            lst_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_data_reg.range_sum    <= acc_sum_reg;
                    out_data_reg.range_active <= acc_act_reg;
                    out_data_reg.status       <= status_reg;
                end
            end
            default:
            begin
                tag_right_reg <= tag_right_reg;
            end
        endcase
    end

    lst_ram #(
        .WIDTH (lst_pkg::NODE_DW),
        .DEPTH (lst_pkg::TREE_NODES)
    ) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (mem_waddr),
        .wdata (node_wdata),
        .raddr (mem_raddr),
        .rdata (node_rdata)
    );

    lst_ram #(
        .WIDTH (lst_pkg::SUM_W),
        .DEPTH (lst_pkg::TREE_NODES)
    ) u_pend_ram (
        .clk   (clk),
        .we    (pend_we),
        .waddr (mem_waddr),
        .wdata (pend_wdata),
        .raddr (mem_raddr),
        .rdata (pend_rdata)
    );

endmodule

`default_nettype wire

>>> hdl/lst_checker.sv
// Port-level checker for the lazy segment tree block and its bind statement.
`default_nettype none
`include "lazy_segment_tree_add_sum_top_macros.svh"

module lst_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire lst_pkg::out_item_t out_data,
    input wire logic               cfg_valid,
    input wire logic               cfg_ready
);

    // A held result stays offered with the same contents until its transfer.
    `LST_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")
    `LST_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data), "result changed")

    // One operation at a time: the input closes after each transfer.
    `LST_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "input stayed open")

    // A configuration write starts the clearing pass.
    `LST_ASSERT_NEXT(a_cfg_clears, cfg_valid && cfg_ready, !in_ready, "no clearing pass")

    // A rejected operation carries an all-zero answer.
    `LST_ASSERT_NOW(a_reject_zero, out_valid && out_data.status,
        (out_data.range_sum == '0) && (out_data.range_active == '0), "rejected result not zero")

endmodule

bind lazy_segment_tree_add_sum_top lst_checker u_lst_checker (.*);

`default_nettype wire
